### rtl/json_string_unescape_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the JSON string unescaper
// Shared concurrent checks, each clocked and held off while reset is low.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JSU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("json_string_unescape: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("json_string_unescape: next-cycle check failed");

`endif

### rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Types and constants shared by the JSON string unescaper modules.
// ----------------------------------------------------------------------------
package jsu_pkg;

	// End status codes carried on the closing word of a string.
	localparam logic [1:0] ST_CLOSED  = 2'd0;
	localparam logic [1:0] ST_UNTERM  = 2'd1;
	localparam logic [1:0] ST_NOQUOTE = 2'd2;

	// Largest number of decoded bytes that one input byte can release.
	localparam int PKT_BYTES = 7;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       string_done;
		logic [1:0] end_status;
	} out_t;

	// Everything one input byte produces: a run of decoded bytes,
	// optionally followed by a closing status word.
	typedef struct packed {
		logic [PKT_BYTES-1:0][7:0] data;
		logic [2:0]                cnt;
		logic                      done;
		logic [1:0]                status;
	} pkt_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef struct packed {
		logic at_open;
		logic high_pending;
	} fr_stat_t;

endpackage

### rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Accepts raw string bytes, tracks the escape state and turns each byte
// into a packet of decoded UTF-8 bytes and an optional closing status.
// ----------------------------------------------------------------------------
module jsu_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	input  jsu_pkg::in_t      data,
	input  logic              q_full,
	output logic              push,
	output jsu_pkg::pkt_t     pkt,
	output jsu_pkg::fr_stat_t stat
);

	typedef enum logic [5:0] {
		PH_OPEN       = 6'b000001,
		PH_BODY       = 6'b000010,
		PH_ESC        = 6'b000100,
		PH_DIGITS     = 6'b001000,
		PH_AFTER_HIGH = 6'b010000,
		PH_HIGH_BSL   = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [3:0][7:0] b;
		logic [2:0]      len;
	} utf8_t;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] C_LF     = 8'h0A;
	localparam logic [7:0] C_TAB    = 8'h09;
	localparam logic [7:0] C_CR     = 8'h0D;
	localparam logic [7:0] C_BS     = 8'h08;
	localparam logic [7:0] C_FF     = 8'h0C;
	localparam logic [20:0] CP_SUPP = 21'h10000;

	phase_t      phase_q, ph_d;
	logic [11:0] hex_q, hex_d;
	logic [1:0]  cnt_q, cnt_d;
	logic        hp_q, hp_d;
	logic [9:0]  hh_q, hh_d;
	logic [7:0]  dig_q [3];

	logic        accept;
	logic [7:0]  b;
	logic        eoi;
	logic [4:0]  hx;
	logic [15:0] v;
	logic [20:0] pair_cp;
	logic [7:0]  esc_c;
	utf8_t       enc;
	logic        store;
	logic        do_flush, do_replay, do_body, do_esc, do_ustart, do_cp, chk_end;

	function automatic logic [4:0] hex_val(input logic [7:0] x);
		logic [4:0] r;
		r = '0;
		if (x >= CH_0 && x <= CH_9) begin
			r = {1'b1, x[3:0]};
		end else if ((x >= CH_UA && x <= CH_UF) || (x >= CH_LA && x <= CH_LF)) begin
			r = {1'b1, x[3:0] + 4'd9};
		end
		return r;
	endfunction

	function automatic utf8_t utf8_enc(input logic [20:0] cp);
		utf8_t e;
		e = '0;
		if (cp < 21'h80) begin
			e.b[0] = cp[7:0];
			e.len  = 3'd1;
		end else if (cp < 21'h800) begin
			e.b[0] = {3'b110, cp[10:6]};
			e.b[1] = {2'b10, cp[5:0]};
			e.len  = 3'd2;
		end else if (cp < 21'h10000) begin
			e.b[0] = {4'b1110, cp[15:12]};
			e.b[1] = {2'b10, cp[11:6]};
			e.b[2] = {2'b10, cp[5:0]};
			e.len  = 3'd3;
		end else begin
			e.b[0] = {5'b11110, cp[20:18]};
			e.b[1] = {2'b10, cp[17:12]};
			e.b[2] = {2'b10, cp[11:6]};
			e.b[3] = {2'b10, cp[5:0]};
			e.len  = 3'd4;
		end
		return e;
	endfunction

	function automatic jsu_pkg::pkt_t push_byte(input jsu_pkg::pkt_t p, input logic [7:0] x);
		jsu_pkg::pkt_t r;
		r = p;
		if (r.cnt < 3'(jsu_pkg::PKT_BYTES)) begin
			r.data[r.cnt] = x;
			r.cnt         = r.cnt + 3'd1;
		end
		return r;
	endfunction

	// U+FFFD in UTF-8.
	function automatic jsu_pkg::pkt_t push_repl(input jsu_pkg::pkt_t p);
		jsu_pkg::pkt_t r;
		r = push_byte(p, 8'hEF);
		r = push_byte(r, 8'hBF);
		r = push_byte(r, 8'hBD);
		return r;
	endfunction

	function automatic jsu_pkg::pkt_t push_enc(input jsu_pkg::pkt_t p, input utf8_t e);
		jsu_pkg::pkt_t r;
		r = p;
		for (int k = 0; k < 4; k++) begin
			if (3'(k) < e.len) begin
				r = push_byte(r, e.b[k]);
			end
		end
		return r;
	endfunction

	assign accept = valid && !q_full;
	assign b      = data.in_byte;
	assign eoi    = data.end_of_input;
	assign hx     = hex_val(b);
	assign v      = {hex_q, hx[3:0]};
	assign pair_cp = CP_SUPP + {1'b0, hh_q, v[9:0]};
	assign enc    = utf8_enc((hp_q && v[15:10] == 6'b110111) ? pair_cp :
		(v[15:11] == 5'b11011) ? 21'h0FFFD : {5'b0, v});

	always_comb begin
		case (b)
			CH_N:    esc_c = C_LF;
			CH_T:    esc_c = C_TAB;
			CH_R:    esc_c = C_CR;
			CH_B:    esc_c = C_BS;
			CH_F:    esc_c = C_FF;
			default: esc_c = b;
		endcase
	end

	// The byte is first dispatched on the phase; the actions it selects then
	// run in the order that fixes the byte order of the packet.
	always_comb begin
		pkt       = '0;
		ph_d      = phase_q;
		hex_d     = hex_q;
		cnt_d     = cnt_q;
		hp_d      = hp_q;
		hh_d      = hh_q;
		store     = 1'b0;
		do_flush  = 1'b0;
		do_replay = 1'b0;
		do_body   = 1'b0;
		do_esc    = 1'b0;
		do_ustart = 1'b0;
		do_cp     = 1'b0;
		chk_end   = 1'b0;

		unique case (phase_q)
			PH_OPEN: begin
				hex_d = '0;
				cnt_d = '0;
				hp_d  = 1'b0;
				if (b == CH_QUOTE) begin
					ph_d    = PH_BODY;
					chk_end = eoi;
				end else begin
					pkt.done   = 1'b1;
					pkt.status = jsu_pkg::ST_NOQUOTE;
				end
			end
			PH_BODY: do_body = 1'b1;
			PH_ESC: begin
				if (b == CH_U) do_ustart = 1'b1;
				else           do_esc    = 1'b1;
			end
			PH_DIGITS: begin
				if (hx[4] && (cnt_q == 2'd3 || !eoi)) begin
					if (cnt_q != 2'd3) begin
						store = 1'b1;
						hex_d = {hex_q[7:0], hx[3:0]};
						cnt_d = cnt_q + 2'd1;
					end else begin
						do_cp = 1'b1;
					end
				end else begin
					do_flush  = 1'b1;
					do_replay = 1'b1;
					do_body   = 1'b1;
				end
			end
			PH_AFTER_HIGH: begin
				if (b == CH_BSL && !eoi) begin
					ph_d = PH_HIGH_BSL;
				end else begin
					do_flush = 1'b1;
					do_body  = 1'b1;
				end
			end
			PH_HIGH_BSL: begin
				if (b == CH_U) begin
					do_ustart = 1'b1;
				end else begin
					do_flush = 1'b1;
					do_esc   = 1'b1;
				end
			end
			default: ;
		endcase

		if (do_flush && hp_d) begin
			pkt  = push_repl(pkt);
			hp_d = 1'b0;
		end
		if (do_replay) begin
			for (int i = 0; i < 3; i++) begin
				if (2'(i) < cnt_q) pkt = push_byte(pkt, dig_q[i]);
			end
			cnt_d = '0;
			hex_d = '0;
		end
		if (do_body) begin
			if (b == CH_QUOTE) begin
				pkt.done   = 1'b1;
				pkt.status = jsu_pkg::ST_CLOSED;
				ph_d       = PH_OPEN;
				hex_d      = '0;
				cnt_d      = '0;
				hp_d       = 1'b0;
			end else if (b == CH_BSL && !eoi) begin
				ph_d = PH_ESC;
			end else begin
				pkt     = push_byte(pkt, b);
				ph_d    = PH_BODY;
				chk_end = eoi;
			end
		end
		if (do_esc) begin
			pkt     = push_byte(pkt, esc_c);
			ph_d    = PH_BODY;
			chk_end = eoi;
		end
		if (do_ustart) begin
			hex_d   = '0;
			cnt_d   = '0;
			ph_d    = PH_DIGITS;
			chk_end = eoi;
		end
		if (do_cp) begin
			cnt_d = '0;
			hex_d = '0;
			ph_d  = PH_BODY;
			if (hp_q && v[15:10] == 6'b110111) begin
				pkt  = push_enc(pkt, enc);
				hp_d = 1'b0;
			end else begin
				// A pending high half without its low half is replaced first.
				if (hp_q) begin
					pkt  = push_repl(pkt);
					hp_d = 1'b0;
				end
				if (v[15:10] == 6'b110110) begin
					hh_d = v[9:0];
					hp_d = 1'b1;
					ph_d = PH_AFTER_HIGH;
				end else begin
					pkt = push_enc(pkt, enc);
				end
			end
			chk_end = eoi;
		end
		if (chk_end) begin
			if (hp_d) pkt = push_repl(pkt);
			pkt.done   = 1'b1;
			pkt.status = jsu_pkg::ST_UNTERM;
			ph_d       = PH_OPEN;
			hex_d      = '0;
			cnt_d      = '0;
			hp_d       = 1'b0;
		end
	end

	assign push = accept && (pkt.cnt != 3'd0 || pkt.done);
	assign stat.at_open      = (phase_q == PH_OPEN);
	assign stat.high_pending = hp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OPEN;
			hex_q   <= '0;
			cnt_q   <= '0;
			hp_q    <= 1'b0;
			hh_q    <= '0;
		end else if (accept) begin
			phase_q <= ph_d;
			hex_q   <= hex_d;
			cnt_q   <= cnt_d;
			hp_q    <= hp_d;
			hh_q    <= hh_d;
		end
	end

	// Raw digit bytes are kept only for replay of a broken escape.
	always_ff @(posedge clk) begin
		if (accept && store) begin
			dig_q[cnt_q] <= b;
		end
	end

endmodule

### rtl/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Short packet queue between the decode front and the output back end.
// ----------------------------------------------------------------------------
module jsu_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  jsu_pkg::pkt_t   wr_pkt,
	input  logic            pop,
	output jsu_pkg::pkt_t   head,
	output jsu_pkg::qstat_t stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	jsu_pkg::pkt_t slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_pkt;
		end
	end

endmodule

### rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Walks the packet at the head of the queue and hands out one result
// word per cycle, unless the output stalls, through an output register.
// ----------------------------------------------------------------------------
module jsu_back (
	input  logic            clk,
	input  logic            arst_n,
	input  jsu_pkg::pkt_t   head,
	input  jsu_pkg::qstat_t qstat,
	output logic            pop,
	output logic            valid,
	input  logic            stall,
	output jsu_pkg::out_t   data
);

	logic [2:0]    idx_q;
	logic          valid_q;
	jsu_pkg::out_t out_q;
	jsu_pkg::out_t item;
	logic          advance;
	logic          last;

	always_comb begin
		item = '0;
		if (idx_q < head.cnt) begin
			item.out_byte   = head.data[idx_q];
			item.byte_valid = 1'b1;
		end else begin
			item.string_done = 1'b1;
			item.end_status  = head.status;
		end
	end

	// A packet ends on its status word if it has one, else on its last byte.
	assign last    = head.done ? (idx_q == head.cnt) : (idx_q == head.cnt - 3'd1);
	assign advance = !qstat.empty && (!valid_q || !stall);
	assign pop     = advance && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (advance) begin
				idx_q   <= last ? 3'd0 : idx_q + 3'd1;
				valid_q <= 1'b1;
			end else if (!stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= item;
		end
	end

	assign valid = valid_q;
	assign data  = out_q;

endmodule

### rtl/json_string_unescape.sv
// ----------------------------------------------------------------------------
// json_string_unescape: an accepted byte passes a queue slot and the output register
// before its first result word. One input byte and one result word per cycle unless
// stalled. A byte with k result words holds the output; meanwhile the queue takes
// QUEUE_DEPTH - 1 more packets, then the input stalls until the head packet has
// drained. Reset clears the escape state and the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "json_string_unescape_assert.svh"

module json_string_unescape #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          raw_valid,
	output logic          raw_stall,
	input  jsu_pkg::in_t  raw,
	output logic          dec_valid,
	input  logic          dec_stall,
	output jsu_pkg::out_t dec
);

	logic              fr_push;
	jsu_pkg::pkt_t     fr_pkt;
	jsu_pkg::fr_stat_t fr_stat;
	jsu_pkg::pkt_t     q_head;
	jsu_pkg::qstat_t   q_stat;
	logic              q_pop;

	assign raw_stall = q_stat.full;

	jsu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (raw_valid),
		.data   (raw),
		.q_full (q_stat.full),
		.push   (fr_push),
		.pkt    (fr_pkt),
		.stat   (fr_stat)
	);

	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fr_push),
		.wr_pkt (fr_pkt),
		.pop    (q_pop),
		.head   (q_head),
		.stat   (q_stat)
	);

	jsu_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.qstat  (q_stat),
		.pop    (q_pop),
		.valid  (dec_valid),
		.stall  (dec_stall),
		.data   (dec)
	);

	`JSU_ASSERT_NEXT(a_done_returns_open, clk, arst_n, fr_push && fr_pkt.done,
		fr_stat.at_open && !fr_stat.high_pending)
	`JSU_ASSERT_IMPLY(a_status_word_clean, clk, arst_n, dec_valid && dec.string_done,
		!dec.byte_valid && dec.out_byte == 8'h00)
	`JSU_ASSERT_IMPLY(a_byte_word_clean, clk, arst_n, dec_valid && dec.byte_valid,
		!dec.string_done && dec.end_status == jsu_pkg::ST_CLOSED)
	`JSU_ASSERT_NEXT(a_no_word_from_empty, clk, arst_n, !dec_valid && q_stat.empty, !dec_valid)

endmodule
